// ===== src/pdb_pkg.sv =====
// Shared types and constants for the page dirty bitmap.
`timescale 1ns / 1ps
package pdb_pkg;

	localparam int MAX_PAGES = 65536;
	localparam int ADDR_W    = 48;
	localparam int SHIFT_W   = 6;
	localparam int IDX_W     = 16;
	localparam int CNT_W     = 17;
	localparam int NPG_W     = $clog2(MAX_PAGES + 1);
	localparam int ROW_W     = 64;
	localparam int ROWS      = MAX_PAGES / ROW_W;
	localparam int ROW_AW    = $clog2(ROWS);
	localparam int BIT_AW    = $clog2(ROW_W);
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 64;

	localparam logic [2:0] REQ_SET_ADDR = 3'd0;
	localparam logic [2:0] REQ_GET_ADDR = 3'd1;
	localparam logic [2:0] REQ_SET_IDX  = 3'd2;
	localparam logic [2:0] REQ_GET_IDX  = 3'd3;
	localparam logic [2:0] REQ_CLEAR    = 3'd4;

	localparam logic [1:0] REG_BASE   = 2'd0;
	localparam logic [1:0] REG_REGION = 2'd1;
	localparam logic [1:0] REG_SHIFT  = 2'd2;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [ADDR_W-1:0] addr;
		logic [IDX_W-1:0]  page_index;
		logic              set_value;
		logic              default_value;
	} req_t;

	typedef struct packed {
		logic             in_range;
		logic             bit_value;
		logic [CNT_W-1:0] marked_count;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  base_addr;
		logic [ADDR_W-1:0]  region_bytes;
		logic [SHIFT_W-1:0] page_shift;
		logic [NPG_W-1:0]   num_pages;
	} cfg_t;

endpackage

// ===== src/pdb_ram.sv =====
// Simple dual-port RAM, one write port and one registered read port.
`timescale 1ns / 1ps
module pdb_ram #(
	parameter int DATA_W = 64,
	parameter int DEPTH  = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/pdb_cfg.sv =====
// APB register file and page count derivation.
`timescale 1ns / 1ps
module pdb_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pdb_pkg::PADDR_W-1:0]  paddr,
	input  logic [pdb_pkg::PDATA_W-1:0]  pwdata,
	output logic [pdb_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output pdb_pkg::cfg_t                cfg
);
	import pdb_pkg::*;

	logic [ADDR_W-1:0]  base_q;
	logic [ADDR_W-1:0]  region_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [NPG_W-1:0]   npg_q;
	logic [ADDR_W-1:0]  pages_raw;
	logic [1:0]         reg_idx;
	logic               wr_en;

	assign reg_idx   = paddr[PADDR_W-1:3];
	assign wr_en     = psel && penable && pwrite;
	assign pready    = 1'b1;
	assign pages_raw = region_q >> shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			region_q <= '0;
			shift_q  <= SHIFT_W'(12);
			npg_q    <= '0;
		end else begin
			if (wr_en) begin
				case (reg_idx)
					REG_BASE:   base_q   <= pwdata[ADDR_W-1:0];
					REG_REGION: region_q <= pwdata[ADDR_W-1:0];
					REG_SHIFT:  shift_q  <= pwdata[SHIFT_W-1:0];
					default: ;
				endcase
			end
			if (pages_raw > ADDR_W'(MAX_PAGES)) begin
				npg_q <= NPG_W'(MAX_PAGES);
			end else begin
				npg_q <= pages_raw[NPG_W-1:0];
			end
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BASE:   prdata = PDATA_W'(base_q);
			REG_REGION: prdata = PDATA_W'(region_q);
			REG_SHIFT:  prdata = PDATA_W'(shift_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.base_addr    = base_q;
	assign cfg.region_bytes = region_q;
	assign cfg.page_shift   = shift_q;
	assign cfg.num_pages    = npg_q;

endmodule

// ===== src/page_dirty_bitmap_unit.sv =====
// Page dirty bitmap: address decode pipeline, row RMW on the bitmap RAM, clear sweep.
// Pipelined with a registered response; one request per cycle while req_stall is low.
// Bitmap is 1024 rows of 64 bits; a row read-modify-write forwards from the previous write.
// Clear all: result is delivered, then a sweep over every row during which no request is taken.
// Reset: the same clearing pass runs first; config writes are taken throughout.
`timescale 1ns / 1ps
module page_dirty_bitmap_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pdb_pkg::PADDR_W-1:0]  paddr,
	input  logic [pdb_pkg::PDATA_W-1:0]  pwdata,
	output logic [pdb_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  pdb_pkg::req_t                req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output pdb_pkg::rsp_t                rsp
);
	import pdb_pkg::*;

	cfg_t cfg;

	// stage 1
	logic              v_s1;
	req_t              req_s1;
	// stage 2
	logic              v_s2;
	logic [2:0]        kind_s2;
	logic [ADDR_W-1:0] off_s2;
	logic              aok_s2;
	logic [IDX_W-1:0]  pidx_s2;
	logic              set_s2;
	logic              dflt_s2;
	// stage 3
	logic              v_s3;
	logic [2:0]        kind_s3;
	logic              hit_s3;
	logic [ROW_AW-1:0] row_s3;
	logic [BIT_AW-1:0] bit_s3;
	logic              set_s3;
	logic              dflt_s3;
	logic              fwd_s3;
	logic [ROW_W-1:0]  fwdd_s3;

	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic [CNT_W-1:0]  count_q;
	logic              busy_q;
	logic [ROW_AW-1:0] sweep_q;

	logic              adv;
	logic              accept;
	logic              clr_in_pipe;
	logic [ADDR_W:0]   limit_s1;
	logic              aok_s1;
	logic [ADDR_W-1:0] off_s1;
	logic [ADDR_W-1:0] shifted_s2;
	logic              hit_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [ROW_W-1:0]  rdata;
	logic [ROW_W-1:0]  cur_row;
	logic [ROW_W-1:0]  new_row;
	logic              old_bit;
	logic              s3_wr;
	logic [CNT_W-1:0]  count_nxt;
	logic              bit_out;
	logic              ram_we;
	logic [ROW_AW-1:0] ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;
	logic              ram_re;

	pdb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pdb_ram #(
		.DATA_W (ROW_W),
		.DEPTH  (ROWS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_s2[IDX_W-1:BIT_AW]),
		.rdata (rdata)
	);

	assign adv         = !rsp_valid_q || !rsp_stall;
	assign clr_in_pipe = (v_s1 && req_s1.req_type == REQ_CLEAR) ||
	                     (v_s2 && kind_s2 == REQ_CLEAR) ||
	                     (v_s3 && kind_s3 == REQ_CLEAR);
	assign req_stall   = !adv || busy_q || clr_in_pipe;
	assign accept      = req_valid && !req_stall;

	// stage 1: region bounds and offset
	assign limit_s1 = {1'b0, cfg.base_addr} + {1'b0, cfg.region_bytes};
	assign aok_s1   = (req_s1.addr >= cfg.base_addr) && ({1'b0, req_s1.addr} < limit_s1);
	assign off_s1   = req_s1.addr - cfg.base_addr;

	// stage 2: page index and map bound
	assign shifted_s2 = off_s2 >> cfg.page_shift;

	always_comb begin
		hit_s2 = 1'b0;
		idx_s2 = pidx_s2;
		if (kind_s2 inside {REQ_SET_ADDR, REQ_GET_ADDR}) begin
			idx_s2 = shifted_s2[IDX_W-1:0];
			hit_s2 = aok_s2 && (shifted_s2 < ADDR_W'(cfg.num_pages));
		end else if (kind_s2 inside {REQ_SET_IDX, REQ_GET_IDX}) begin
			hit_s2 = NPG_W'(pidx_s2) < cfg.num_pages;
		end
	end

	assign ram_re = adv && v_s2;

	// stage 3: row modify
	assign cur_row = fwd_s3 ? fwdd_s3 : rdata;
	assign old_bit = cur_row[bit_s3];

	always_comb begin
		new_row         = cur_row;
		new_row[bit_s3] = set_s3;
	end

	assign s3_wr = v_s3 && hit_s3 && (kind_s3 inside {REQ_SET_ADDR, REQ_SET_IDX});

	always_comb begin
		count_nxt = count_q;
		bit_out   = 1'b0;
		if (kind_s3 == REQ_CLEAR) begin
			count_nxt = '0;
		end else if (s3_wr && (old_bit != set_s3)) begin
			count_nxt = set_s3 ? count_q + CNT_W'(1) : count_q - CNT_W'(1);
		end
		if (kind_s3 inside {REQ_GET_ADDR, REQ_GET_IDX}) begin
			bit_out = hit_s3 ? old_bit : dflt_s3;
		end
	end

	always_comb begin
		if (busy_q) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_q;
			ram_wdata = '0;
		end else begin
			ram_we    = adv && s3_wr;
			ram_waddr = row_s3;
			ram_wdata = new_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
			busy_q      <= 1'b1;
			sweep_q     <= '0;
			fwd_s3      <= 1'b0;
		end else begin
			if (adv) begin
				v_s1        <= accept;
				v_s2        <= v_s1;
				v_s3        <= v_s2;
				rsp_valid_q <= v_s3;
				fwd_s3      <= s3_wr && (row_s3 == idx_s2[IDX_W-1:BIT_AW]);
				if (v_s3) begin
					count_q <= count_nxt;
				end
			end
			if (busy_q) begin
				if (sweep_q == ROW_AW'(ROWS - 1)) begin
					busy_q  <= 1'b0;
					sweep_q <= '0;
				end else begin
					sweep_q <= sweep_q + ROW_AW'(1);
				end
			end else if (adv && v_s3 && kind_s3 == REQ_CLEAR) begin
				busy_q  <= 1'b1;
				sweep_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (adv) begin
			kind_s2 <= req_s1.req_type;
			off_s2  <= off_s1;
			aok_s2  <= aok_s1;
			pidx_s2 <= req_s1.page_index;
			set_s2  <= req_s1.set_value;
			dflt_s2 <= req_s1.default_value;

			kind_s3 <= kind_s2;
			hit_s3  <= hit_s2;
			row_s3  <= idx_s2[IDX_W-1:BIT_AW];
			bit_s3  <= idx_s2[BIT_AW-1:0];
			set_s3  <= set_s2;
			dflt_s3 <= dflt_s2;
			fwdd_s3 <= new_row;

			if (v_s3) begin
				rsp_q.in_range     <= hit_s3;
				rsp_q.bit_value    <= bit_out;
				rsp_q.marked_count <= count_nxt;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
